>>> hdl/gdd_pkg.sv
// shared types, codes and calendar tables for the gregorian date difference block
// no dependencies
`default_nettype none

package gdd_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int GAP_W     = 22;
    localparam int QUOT_W    = 8;
    localparam int MOFF_W    = 9;
    localparam int RECIP_W   = 13;
    localparam int PROD_W    = YEAR_W + RECIP_W;
    localparam int RECIP_SH  = 19;

    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP  = 5'd29;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FIRST_BAD  = 2'd1,
        STATUS_SECOND_BAD = 2'd2
    } t_status;

    typedef struct packed {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic               second_is_earlier;
        logic [GAP_W-1:0]   day_gap;
    } t_out_item;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_adv;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before m in a common year
    function automatic logic [MOFF_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            4'd13, 4'd14, 4'd15: n = 9'd365;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> hdl/gdd_date_ordinal.sv
// three stage pipeline: checks one date and turns it into an ordinal day number
// depends on gdd_pkg
`default_nettype none

module gdd_date_ordinal
    import gdd_pkg::*;
(
    input  wire                 i_clk,
    input  wire t_adv           i_adv,
    input  wire [YEAR_W-1:0]    i_year,
    input  wire [MONTH_W-1:0]   i_month,
    input  wire [DAY_W-1:0]     i_day,
    output logic [GAP_W-1:0]    o_ord,
    output logic                o_ok
);

    logic [YEAR_W-1:0]  w_prev;
    logic [PROD_W-1:0]  w_prod_y;
    logic [PROD_W-1:0]  w_prod_p;

    logic [YEAR_W-1:0]  r1_year;
    logic [MONTH_W-1:0] r1_month;
    logic [DAY_W-1:0]   r1_day;
    logic [GAP_W-1:0]   r1_p365;
    logic [QUOT_W-1:0]  r1_qy;
    logic [QUOT_W-1:0]  r1_qp;

    logic [YEAR_W-1:0]  w1_prev;
    logic [YEAR_W-1:0]  w1_hund;
    logic               w1_leap;
    logic [DAY_W-1:0]   w1_lim;
    logic               w1_ok;
    logic [GAP_W-1:0]   w1_yd;
    logic [MOFF_W-1:0]  w1_moff;

    logic [GAP_W-1:0]   r2_yd;
    logic [MOFF_W-1:0]  r2_moff;
    logic [DAY_W-1:0]   r2_day;
    logic               r2_ok;

    logic [GAP_W-1:0]   r3_ord;
    logic               r3_ok;

    assign w_prev   = i_year - YEAR_MIN;
    assign w_prod_y = PROD_W'(i_year) * PROD_W'(RECIP_100);
    assign w_prod_p = PROD_W'(w_prev) * PROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r1_year  <= i_year;
            r1_month <= i_month;
            r1_day   <= i_day;
            r1_p365  <= GAP_W'(w_prev) * GAP_W'(365);
            r1_qy    <= w_prod_y[RECIP_SH +: QUOT_W];
            r1_qp    <= w_prod_p[RECIP_SH +: QUOT_W];
        end
    end

    always_comb begin
        w1_prev = r1_year - YEAR_MIN;
        w1_hund = YEAR_W'(r1_qy) * YEAR_W'(100);
        w1_leap = (r1_year[1:0] == 2'b00) && ((w1_hund != r1_year) || (r1_qy[1:0] == 2'b00));
        w1_lim  = month_len(r1_month);
        if ((r1_month == MONTH_FEB) && w1_leap) begin
            w1_lim = FEB_LEAP;
        end
        w1_ok = (r1_year >= YEAR_MIN) && (r1_year <= YEAR_MAX)
             && (r1_month != '0) && (r1_month <= MONTH_DEC)
             && (r1_day != '0) && (r1_day <= w1_lim);
        w1_yd = r1_p365 + GAP_W'(w1_prev >> 2) - GAP_W'(r1_qp) + GAP_W'(r1_qp >> 2);
        w1_moff = days_before(r1_month);
        if ((r1_month > MONTH_FEB) && w1_leap) begin
            w1_moff = w1_moff + MOFF_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r2_yd   <= w1_yd;
            r2_moff <= w1_moff;
            r2_day  <= r1_day;
            r2_ok   <= w1_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r3_ord <= r2_yd + GAP_W'(r2_moff) + GAP_W'(r2_day);
            r3_ok  <= r2_ok;
        end
    end

    assign o_ord = r3_ord;
    assign o_ok  = r3_ok;

endmodule

`default_nettype wire

>>> hdl/gregorian_date_difference_core.sv
// gregorian date difference: validates two dates per item and reports their day gap
// Input channel: i_in_valid / o_in_stall carry one date pair per item in i_in_item.
// Output channel: o_out_valid / i_out_stall carry status, order flag and day gap.
// An item is taken at a clock edge where valid is high and stall is low.
// The result passes four register stages, the first loaded at the accepting edge, and
// stands on o_out_item once the last of them, the output stage, has been loaded.
// Throughput is one item per cycle while the receiver does not stall: four register
// stages, each holding its own item (reciprocal divides and year scaling, leap and
// month tables, ordinal sum, compare and subtract).
// When the receiver stalls, the output stage holds its result and the stages behind
// it keep filling until every stage is occupied; only then is o_in_stall raised.
// No item is dropped or repeated under stall.
// A synchronous active-low reset on i_rst_n empties the pipeline; the block keeps no
// other state, so it can take an item as soon as reset is released.
// depends on gdd_pkg and gdd_date_ordinal
`default_nettype none

module gregorian_date_difference_core
    import gdd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire t_in_item i_in_item,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output t_out_item   o_out_item
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    t_adv w_adv;

    logic [GAP_W-1:0] w_ord_a, w_ord_b;
    logic             w_ok_a, w_ok_b;
    t_out_item        n_out;
    t_out_item        r_out;

    assign w_rdy4 = !r_v4 || !i_out_stall;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_adv.s1 = w_rdy1;
    assign w_adv.s2 = w_rdy2;
    assign w_adv.s3 = w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    gdd_date_ordinal u_first (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_year  (i_in_item.first_year),
        .i_month (i_in_item.first_month),
        .i_day   (i_in_item.first_day),
        .o_ord   (w_ord_a),
        .o_ok    (w_ok_a)
    );

    gdd_date_ordinal u_second (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_year  (i_in_item.second_year),
        .i_month (i_in_item.second_month),
        .i_day   (i_in_item.second_day),
        .o_ord   (w_ord_b),
        .o_ok    (w_ok_b)
    );

    always_comb begin
        n_out = '0;
        priority if (!w_ok_a) begin
            n_out.status = STATUS_FIRST_BAD;
        end else if (!w_ok_b) begin
            n_out.status = STATUS_SECOND_BAD;
        end else if (w_ord_b <= w_ord_a) begin
            n_out.status            = STATUS_OK;
            n_out.second_is_earlier = 1'b1;
            n_out.day_gap           = w_ord_a - w_ord_b;
        end else begin
            n_out.status            = STATUS_OK;
            n_out.second_is_earlier = 1'b0;
            n_out.day_gap           = w_ord_b - w_ord_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = !w_rdy1;
    assign o_out_valid = r_v4;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != STATUS_OK)
        |-> (o_out_item.day_gap == '0) && !o_out_item.second_is_earlier)
        else $error("invalid date result carries a gap or order flag");
    a_equal_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == STATUS_OK) && (o_out_item.day_gap == '0)
        |-> o_out_item.second_is_earlier)
        else $error("equal dates without second_is_earlier");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output stage is empty");
    a_no_gap_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !w_rdy3 |=> r_v3 && r_v4)
        else $error("stalled stage lost its item");
`endif

endmodule

`default_nettype wire
